// ----- sv/aid_pkg.sv -----
// aid_pkg: shared widths, register codes, reset values and types for the impact detector
// no dependencies; used by accel_impact_detector, aid_cdiv and aid_checker

package aid_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 18;    // x + 2y
    localparam int MEAN_W      = 18;
    localparam int DIFF_W      = 19;
    localparam int MAG_W       = 18;
    localparam int COUNT_W     = 8;
    localparam int HOLD_W      = 17;
    localparam int THRESH_W    = 18;
    localparam int HOLDOFF_W   = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_HIT_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_SAMPLES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DETECT_ENABLE   = 2'd2;

    localparam logic [THRESH_W-1:0]  HIT_THRESHOLD_RESET   = 18'd70000;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_SAMPLES_RESET = 16'd100;

    typedef logic signed [WEIGHT_W-1:0] weight_t;

    // load strobes for the two registers of a constant divider
    typedef struct packed {
        logic load_est;
        logic load_fix;
    } div_ctrl_t;

    // how often window slot `slot` is visited by ages first_age .. first_age+count-1,
    // ages wrapping around the window depth
    function automatic int age_multiplicity(int first_age, int count, int depth, int slot);
        int pos;
        int hits;
        pos  = first_age;
        hits = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (pos >= depth)
                pos = pos - depth;
        end
        for (int k = 0; k < count; k++)
        begin
            if (pos == slot)
                hits = hits + 1;
            pos = pos + 1;
            if (pos == depth)
                pos = 0;
        end
        return hits;
    endfunction

    // weight of old tap `tap` in the running-sum update when the line shifts by one
    function automatic int tap_coef(int first_age, int count, int depth, int tap);
        if (tap < depth - 1)
            return age_multiplicity(first_age, count, depth, tap + 1)
                 - age_multiplicity(first_age, count, depth, tap);
        else
            return -age_multiplicity(first_age, count, depth, depth - 1);
    endfunction

endpackage

// ----- sv/aid_cdiv.sv -----
// aid_cdiv: two-register signed division by a constant, truncating toward zero
// reciprocal multiply then one correction step; uses aid_pkg::div_ctrl_t

module aid_cdiv #(
    parameter int IN_W    = 20,
    parameter int DIVISOR = 3
) (
    input  logic                    clk,
    input  aid_pkg::div_ctrl_t      ctrl,
    input  logic signed [IN_W-1:0]  dividend,
    output logic signed [IN_W-1:0]  quotient
);

    localparam int RECIP_W = IN_W + 1;
    localparam int PROD_W  = IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << IN_W) / DIVISOR);
    localparam logic [IN_W-1:0]    DIV_K = IN_W'(DIVISOR);

    logic [IN_W-1:0]   mag;
    logic [PROD_W-1:0] prod;
    logic [IN_W-1:0]   q_est;
    logic [IN_W-1:0]   rem;
    logic [IN_W-1:0]   q_fix;

    logic [IN_W-1:0]   q_est_reg;
    logic [IN_W-1:0]   mag_reg;
    logic              neg_reg;
    logic [IN_W-1:0]   quotient_reg;

    assign mag   = dividend[IN_W-1] ? IN_W'(-dividend) : IN_W'(dividend);
    assign prod  = PROD_W'(mag) * PROD_W'(RECIP);
    // estimate is exact or one low
    assign q_est = prod[PROD_W-2:IN_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.load_est)
        begin
            q_est_reg <= q_est;
            mag_reg   <= mag;
            neg_reg   <= dividend[IN_W-1];
        end
    end

    assign rem   = mag_reg - IN_W'(q_est_reg * DIV_K);
    assign q_fix = (rem >= DIV_K) ? q_est_reg + IN_W'(1) : q_est_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_fix)
            quotient_reg <= neg_reg ? IN_W'(-q_fix) : q_fix;
    end

    assign quotient = quotient_reg;

endmodule

// ----- sv/accel_impact_detector.sv -----
// accel_impact_detector: impact detection on a stream of x/y accelerometer words
// depends on aid_pkg and aid_cdiv
//
// channel     dir  bits  contents (lowest bit up)
// s_axis      in   32    tdata: accel_x[15:0], accel_y[31:16]; tuser: restart
// m_axis      out  32    tdata: hit_count[7:0], mean_difference[26:8], zeros; tuser: hit
// cfg         in   2/18  cfg_index selects register, cfg_wr_data is written on cfg_wr_en
//
// one word accepted per clock when nothing stalls;
// six register stages from accept to the result register
// stage order: weighting, window and running sums, reciprocal multiply, divide fix-up,
// mean difference, holdoff/hit decision into the output register
// every stage has its own valid bit and loads when empty or when the next one moves,
// so bubbles close up; a waiting result lets at most five more words in, then s_axis_tready drops
// rst_n clears sample window, running sums, counters, valid bits; presets config registers

module accel_impact_detector #(
    parameter int WINDOW_DEPTH = 10,
    parameter int RECENT_COUNT = 3,
    parameter int OLDER_COUNT  = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [aid_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // accel_x, accel_y
    input  logic                                 s_axis_tuser,   // restart

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [aid_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // hit_count, mean_difference
    output logic                                 m_axis_tuser,   // hit

    input  logic                                 cfg_wr_en,
    input  logic [aid_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [aid_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

    // running sums are wide enough for count * most negative weight
    localparam int RSUM_W = aid_pkg::WEIGHT_W + $clog2(RECENT_COUNT + 1);
    localparam int OSUM_W = aid_pkg::WEIGHT_W + $clog2(OLDER_COUNT + 1);
    // weight of the incoming word in each sum
    localparam int R_NEW  = aid_pkg::age_multiplicity(0, RECENT_COUNT, WINDOW_DEPTH, 0);
    localparam int O_NEW  = aid_pkg::age_multiplicity(RECENT_COUNT, OLDER_COUNT,
                                                      WINDOW_DEPTH, 0);
    localparam int PAD_W  = aid_pkg::OUT_TDATA_W - aid_pkg::DIFF_W - aid_pkg::COUNT_W;

    // stage enables: a stage loads when empty or when its successor loads
    logic en1, en2, en3, en4, en5, en_out;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;

    // configuration
    logic [aid_pkg::THRESH_W-1:0]  hit_threshold_reg;
    logic [aid_pkg::HOLDOFF_W-1:0] holdoff_samples_reg;
    logic                          detect_enable_reg;

    // stage 1: weighting
    logic signed [aid_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [aid_pkg::SAMPLE_W-1:0] accel_y;
    aid_pkg::weight_t                    weight;
    aid_pkg::weight_t                    w1_reg;
    logic                                restart1_reg;

    // stage 2: window taps (age 0 at index 0) and running sums
    aid_pkg::weight_t          tap_reg  [WINDOW_DEPTH];
    aid_pkg::weight_t          tap_next [WINDOW_DEPTH];
    logic signed [RSUM_W-1:0]  rterm    [WINDOW_DEPTH];
    logic signed [OSUM_W-1:0]  oterm    [WINDOW_DEPTH];
    logic signed [RSUM_W-1:0]  rsum_reg, rsum_next;
    logic signed [OSUM_W-1:0]  osum_reg, osum_next;
    logic                      restart2_reg;

    // stages 3 and 4: dividers
    aid_pkg::div_ctrl_t        div_ctrl;
    logic signed [RSUM_W-1:0]  recent_q;
    logic signed [OSUM_W-1:0]  older_q;
    logic                      restart3_reg, restart4_reg;

    // stage 5: mean difference
    logic signed [aid_pkg::MEAN_W-1:0] recent_mean, older_mean;
    logic signed [aid_pkg::DIFF_W-1:0] diff;
    logic signed [aid_pkg::DIFF_W-1:0] diff5_reg;
    logic [aid_pkg::MAG_W-1:0]         mag5_reg;
    logic                              restart5_reg;

    // decision state and result register
    logic [aid_pkg::HOLD_W-1:0]         holdoff_count_reg, holdoff_count_next, hold_base;
    logic [aid_pkg::COUNT_W-1:0]        hits_reg, hits_next, hits_base;
    logic                               hit_flag;
    logic signed [aid_pkg::DIFF_W-1:0]  diff_out;
    logic                               m_hit_reg;
    logic [aid_pkg::COUNT_W-1:0]        m_count_reg;
    logic signed [aid_pkg::DIFF_W-1:0]  m_diff_reg;

    // ---------------------------------------------------------------- flow control
    assign en_out        = !m_valid_reg || m_axis_tready;
    assign en5           = !v5_reg || en_out;
    assign en4           = !v4_reg || en5;
    assign en3           = !v3_reg || en4;
    assign en2           = !v2_reg || en3;
    assign en1           = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
            if (en_out)
                m_valid_reg <= v5_reg;
        end
    end

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_threshold_reg   <= aid_pkg::HIT_THRESHOLD_RESET;
            holdoff_samples_reg <= aid_pkg::HOLDOFF_SAMPLES_RESET;
            detect_enable_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                aid_pkg::REG_HIT_THRESHOLD:
                    hit_threshold_reg <= cfg_wr_data;
                aid_pkg::REG_HOLDOFF_SAMPLES:
                    holdoff_samples_reg <= cfg_wr_data[aid_pkg::HOLDOFF_W-1:0];
                aid_pkg::REG_DETECT_ENABLE:
                    detect_enable_reg <= cfg_wr_data[0];
                default:
                    ;   // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 1: x + 2y
    assign accel_x = s_axis_tdata[aid_pkg::SAMPLE_W-1:0];
    assign accel_y = s_axis_tdata[2*aid_pkg::SAMPLE_W-1:aid_pkg::SAMPLE_W];
    assign weight  = aid_pkg::WEIGHT_W'(accel_x) + (aid_pkg::WEIGHT_W'(accel_y) <<< 1);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            w1_reg       <= weight;
            restart1_reg <= s_axis_tuser;
        end
    end

    // ---------------------------------------------------------------- stage 2: window
    // the sums are kept as sum over slots of multiplicity * tap; when the line shifts,
    // the change only involves taps where the multiplicity steps, so at most a few
    // of the terms below carry a nonzero weight and the rest fold away
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_tap
        localparam int RC = aid_pkg::tap_coef(0, RECENT_COUNT, WINDOW_DEPTH, i);
        localparam int OC = aid_pkg::tap_coef(RECENT_COUNT, OLDER_COUNT, WINDOW_DEPTH, i);

        assign rterm[i] = (RC == 0) ? '0 : RSUM_W'(RC) * RSUM_W'(tap_reg[i]);
        assign oterm[i] = (OC == 0) ? '0 : OSUM_W'(OC) * OSUM_W'(tap_reg[i]);

        if (i == 0)
        begin : g_head
            assign tap_next[i] = w1_reg;
        end
        else
        begin : g_body
            assign tap_next[i] = tap_reg[i-1];
        end
    end

    always_comb
    begin
        rsum_next = rsum_reg + RSUM_W'(R_NEW) * RSUM_W'(w1_reg);
        osum_next = osum_reg + OSUM_W'(O_NEW) * OSUM_W'(w1_reg);
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            rsum_next = rsum_next + rterm[i];
            osum_next = osum_next + oterm[i];
        end
    end

    // the window is block state: reset to zero samples, shifts only on a real word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
                tap_reg[i] <= '0;
            rsum_reg <= '0;
            osum_reg <= '0;
        end
        else if (en2 && v1_reg)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
                tap_reg[i] <= tap_next[i];
            rsum_reg <= rsum_next;
            osum_reg <= osum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
            restart2_reg <= restart1_reg;
    end

    // ---------------------------------------------------------------- stages 3-4: means
    assign div_ctrl.load_est = en3;
    assign div_ctrl.load_fix = en4;

    aid_cdiv #(
        .IN_W    (RSUM_W),
        .DIVISOR (RECENT_COUNT)
    ) u_recent_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (rsum_reg),
        .quotient (recent_q)
    );

    aid_cdiv #(
        .IN_W    (OSUM_W),
        .DIVISOR (OLDER_COUNT)
    ) u_older_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (osum_reg),
        .quotient (older_q)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
            restart3_reg <= restart2_reg;
        if (en4)
            restart4_reg <= restart3_reg;
    end

    // ---------------------------------------------------------------- stage 5: difference
    assign recent_mean = aid_pkg::MEAN_W'(recent_q);
    assign older_mean  = aid_pkg::MEAN_W'(older_q);
    assign diff        = aid_pkg::DIFF_W'(recent_mean) - aid_pkg::DIFF_W'(older_mean);

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            diff5_reg    <= diff;
            mag5_reg     <= diff[aid_pkg::DIFF_W-1] ? aid_pkg::MAG_W'(-diff)
                                                    : aid_pkg::MAG_W'(diff);
            restart5_reg <= restart4_reg;
        end
    end

    // ---------------------------------------------------------------- decision
    assign hold_base = restart5_reg ? '0 : holdoff_count_reg;
    assign hits_base = restart5_reg ? '0 : hits_reg;

    always_comb
    begin
        holdoff_count_next = holdoff_count_reg;
        hits_next          = hits_reg;
        hit_flag           = 1'b0;
        diff_out           = '0;
        if (en_out && v5_reg)
        begin
            holdoff_count_next = hold_base;
            hits_next          = hits_base;
            // holdoff climbs until one past its limit, then detection is armed
            if (hold_base <= aid_pkg::HOLD_W'(holdoff_samples_reg))
                holdoff_count_next = hold_base + aid_pkg::HOLD_W'(1);
            else if (detect_enable_reg)
            begin
                diff_out = diff5_reg;
                if (mag5_reg > hit_threshold_reg)
                begin
                    hits_next          = hits_base + aid_pkg::COUNT_W'(1);
                    holdoff_count_next = '0;
                    hit_flag           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_count_reg <= '0;
            hits_reg          <= '0;
        end
        else
        begin
            holdoff_count_reg <= holdoff_count_next;
            hits_reg          <= hits_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (en_out && v5_reg)
        begin
            m_hit_reg   <= hit_flag;
            m_count_reg <= hits_next;
            m_diff_reg  <= diff_out;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_hit_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_diff_reg, m_count_reg};

endmodule

// ----- sv/aid_checker.sv -----
// aid_checker: port-level checks for accel_impact_detector, attached by bind
// depends on aid_pkg widths only

module aid_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [aid_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);

    localparam int DIFF_LO = aid_pkg::COUNT_W;
    localparam int DIFF_HI = aid_pkg::COUNT_W + aid_pkg::DIFF_W - 1;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // nothing leaves the block while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // a hit needs a mean difference beyond an unsigned threshold, so never zero
    a_hit_diff: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[DIFF_HI:DIFF_LO] != '0)
        else $error("hit reported with zero mean difference");

    // padding above the packed fields stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[aid_pkg::OUT_TDATA_W-1:DIFF_HI+1] == '0)
        else $error("nonzero padding in result word");

endmodule

bind accel_impact_detector aid_checker u_aid_checker (.*);

// ----- sim/tb_accel_impact_detector.sv -----
// tb_accel_impact_detector: self-checking bench for the accelerometer impact detector
// depends on aid_pkg and accel_impact_detector; predicts every result word in the bench
// and compares it field by field under random source gaps and sink stalls

module tb_accel_impact_detector;

    localparam int WIN_DEPTH    = 10;
    localparam int RECENT_N     = 3;
    localparam int OLDER_N      = 7;
    localparam int PIPE_LATENCY = 6;
    localparam int CYCLE_LIMIT  = 400000;

    localparam int SAMPLE_W    = aid_pkg::SAMPLE_W;
    localparam int COUNT_W     = aid_pkg::COUNT_W;
    localparam int DIFF_W      = aid_pkg::DIFF_W;
    localparam int HOLD_W      = aid_pkg::HOLD_W;
    localparam int THRESH_W    = aid_pkg::THRESH_W;
    localparam int HOLDOFF_W   = aid_pkg::HOLDOFF_W;
    localparam int IN_TDATA_W  = aid_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = aid_pkg::OUT_TDATA_W;
    localparam int CFG_INDEX_W = aid_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = aid_pkg::CFG_DATA_W;

    // index past the last register, the block must ignore writes to it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic                      hit;
        logic [COUNT_W-1:0]        hit_count;
        logic signed [DIFF_W-1:0]  mean_diff;
    } impact_result_t;

    logic                       clk           = 1'b0;
    logic                       rst_n;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata  = '0;   // accel_x, accel_y
    logic                       s_axis_tuser  = 1'b0; // restart
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;         // hit_count, mean_difference
    logic                       m_axis_tuser;         // hit
    logic                       cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index     = '0;
    logic [CFG_DATA_W-1:0]      cfg_wr_data   = '0;

    // predictor state: sample window, counters and register copies
    logic [SAMPLE_W-1:0]        window_x [WIN_DEPTH];
    logic [SAMPLE_W-1:0]        window_y [WIN_DEPTH];
    int                         newest_slot;
    logic [HOLD_W-1:0]          holdoff_cnt;
    logic [COUNT_W-1:0]         impacts;
    logic [THRESH_W-1:0]        threshold_reg;
    logic [HOLDOFF_W-1:0]       holdoff_reg;
    logic                       detect_en;

    impact_result_t             expected_impacts [$];
    int                         error_count = 0;
    int                         cycle_count = 0;
    int                         sink_stall  = 0;
    bit                         idling_on   = 1'b1;

    accel_impact_detector #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .RECENT_COUNT (RECENT_N),
        .OLDER_COUNT  (OLDER_N)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // x + 2y of the sample `age` words back, age 0 is the newest
    function automatic int weighted_at(int age);
        int slot;
        int wx;
        int wy;
        slot = (newest_slot + WIN_DEPTH - age % WIN_DEPTH) % WIN_DEPTH;
        wx   = $signed(window_x[slot]);
        wy   = $signed(window_y[slot]);
        return wx + 2 * wy;
    endfunction

    // integer division truncates toward zero, as the block does
    function automatic int window_mean(int first_age, int count);
        int total;
        total = 0;
        for (int k = 0; k < count; k++)
            total += weighted_at(first_age + k);
        return total / count;
    endfunction

    // small wander around a baseline, wraps at 16 bits
    function automatic logic [SAMPLE_W-1:0] jitter(int center);
        return SAMPLE_W'(center + int'($urandom_range(0, 256)) - 128);
    endfunction

    // advance the predictor by one accepted word and queue the result it owes
    task automatic predict_impact(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                                  input logic restart);
        impact_result_t r;
        int diff;
        int mag;
        r.hit = 1'b0;
        diff  = 0;
        // restart clears counters before this sample counts
        if (restart)
        begin
            holdoff_cnt = '0;
            impacts     = '0;
        end
        newest_slot           = (newest_slot + 1) % WIN_DEPTH;
        window_x[newest_slot] = x;
        window_y[newest_slot] = y;
        // holdoff climbs until one past its limit, then detection may run
        if (holdoff_cnt <= holdoff_reg)
            holdoff_cnt = holdoff_cnt + 1'b1;
        else if (detect_en)
        begin
            diff = window_mean(0, RECENT_N) - window_mean(RECENT_N, OLDER_N);
            mag  = (diff < 0) ? -diff : diff;
            if (mag > int'(threshold_reg))
            begin
                impacts     = impacts + 1'b1;
                holdoff_cnt = '0;
                r.hit       = 1'b1;
            end
        end
        r.hit_count = impacts;
        r.mean_diff = diff[DIFF_W-1:0];
        expected_impacts.push_back(r);
    endtask

    // one word into s_axis, with an occasional random gap in front while idling is on
    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                               input logic restart);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_impact(x, y, restart);
    endtask

    // stop sending and let every owed result come out, then the pipe settles
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_impacts.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2)
            @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        case (idx)
            aid_pkg::REG_HIT_THRESHOLD:   threshold_reg = value[THRESH_W-1:0];
            aid_pkg::REG_HOLDOFF_SAMPLES: holdoff_reg   = value[HOLDOFF_W-1:0];
            aid_pkg::REG_DETECT_ENABLE:   detect_en     = value[0];
            default:                      ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] hold,
                             input logic en);
        wait_idle();
        write_reg(aid_pkg::REG_HIT_THRESHOLD, thr);
        write_reg(aid_pkg::REG_HOLDOFF_SAMPLES, hold);
        write_reg(aid_pkg::REG_DETECT_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
    endtask

    // mostly a quiet stretch around a baseline followed by a short spike,
    // sometimes plain full-range noise; the quiet stretch may be cut short
    task automatic send_impact_burst(output int sent);
        int base_x;
        int base_y;
        sent = 0;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                            $urandom_range(0, 29) == 0);
                sent++;
            end
        end
        else
        begin
            base_x = int'($urandom_range(0, 8000)) - 4000;
            base_y = int'($urandom_range(0, 8000)) - 4000;
            repeat ($urandom_range(0, 12))
            begin
                send_sample(jitter(base_x), jitter(base_y), $urandom_range(0, 29) == 0);
                sent++;
            end
            repeat ($urandom_range(1, 3))
            begin
                send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                            $urandom_range(0, 29) == 0);
                sent++;
            end
        end
    endtask

    // reset values: detection off, long holdoff, so nothing is evaluated
    task automatic test_reset_defaults();
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b1);
        send_sample(16'h0000, 16'hFFFF, 1'b0);
    endtask

    // detection right away while some window slots still hold reset zeros
    task automatic test_partial_window();
        configure(18'd0, 18'd0, 1'b1);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h7FFF, 16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h0001, 16'h0000, 1'b1);
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        send_sample(16'h0000, 16'h7FFF, 1'b0);
    endtask

    // ignored index, bits above holdoff/enable widths, and a difference exactly at threshold
    task automatic test_register_masking();
        wait_idle();
        write_reg(REG_UNUSED, '0);
        write_reg(aid_pkg::REG_HOLDOFF_SAMPLES, 18'h3_0002);
        write_reg(aid_pkg::REG_DETECT_ENABLE, 18'h2);
        repeat (3)
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0);
        wait_idle();
        write_reg(aid_pkg::REG_DETECT_ENABLE, 18'h1);
        write_reg(aid_pkg::REG_HIT_THRESHOLD, '0);
        // a full window of one value gives zero difference, which must not hit
        repeat (11)
            send_sample(16'h0123, 16'hFF00, 1'b0);
    endtask

    // zero threshold and holdoff: a hit at most on every other word, the count climbs fast
    task automatic test_hit_every_other();
        configure(18'd0, 18'd0, 1'b1);
        send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b1);
        repeat (120)
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0);
    endtask

    // several random settings, plus the largest threshold and holdoff
    task automatic test_random_stream();
        int sent;
        int burst;
        for (int p = 0; p < 4; p++)
        begin
            configure((p == 0) ? 18'd0 : CFG_DATA_W'($urandom_range(0, 90000)),
                      CFG_DATA_W'($urandom_range(0, 12)),
                      (p == 0) || ($urandom_range(0, 4) != 0));
            sent = 0;
            while (sent < 40)
            begin
                send_impact_burst(burst);
                sent += burst;
                // source holds back once until the sink has drained everything
                if (p == 2 && sent >= 20 && sent - burst < 20)
                    wait_idle();
            end
        end
        configure(18'h3FFFF, 18'h0FFFF, 1'b1);
        repeat (15)
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // last stretch with both sides running flat out
    task automatic test_unthrottled_tail();
        int sent;
        int burst;
        configure(18'd20000, 18'd1, 1'b1);
        idling_on = 1'b0;
        sent      = 0;
        while (sent < 60)
        begin
            send_impact_burst(burst);
            sent += burst;
        end
    endtask

    // sink: ready, with random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            sink_stall    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // compare each accepted result word with the oldest owed result
    always @(posedge clk)
    begin
        impact_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_impacts.size() == 0)
            begin
                $error("result word with none owed: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = expected_impacts.pop_front();
                if (m_axis_tuser !== want.hit)
                begin
                    $error("hit: expected %0d actual %0d", want.hit, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[7:0] !== want.hit_count)
                begin
                    $error("hit_count: expected %0d actual %0d",
                           want.hit_count, m_axis_tdata[7:0]);
                    error_count++;
                end
                if (m_axis_tdata[26:8] !== want.mean_diff)
                begin
                    $error("mean_difference: expected %0d actual %0d",
                           want.mean_diff, $signed(m_axis_tdata[26:8]));
                    error_count++;
                end
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            window_x[i] = '0;
            window_y[i] = '0;
        end
        newest_slot   = 0;
        holdoff_cnt   = '0;
        impacts       = '0;
        threshold_reg = aid_pkg::HIT_THRESHOLD_RESET;
        holdoff_reg   = aid_pkg::HOLDOFF_SAMPLES_RESET;
        detect_en     = 1'b0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_partial_window();
        test_register_masking();
        test_hit_every_other();
        test_random_stream();
        test_unthrottled_tail();
        wait_idle();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/aid_pkg.sv
sv/aid_cdiv.sv
sv/accel_impact_detector.sv
sv/aid_checker.sv
sim/tb_accel_impact_detector.sv
